// ===== rtl/ssu_pkg.sv =====
// Shared types, constants and helpers for the submatrix search unit.
// Used by ssu_ctrl, ssu_dp and submatrix_search_unit; no dependencies.
package ssu_pkg;

  localparam int MAX_ROWS = 8;
  localparam int MAX_COLS = 8;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int DIM_W    = 4;
  localparam int CNT_W    = 7;
  localparam int VAL_W    = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] DimMaxRows = DIM_W'(MAX_ROWS);
  localparam logic [DIM_W-1:0] DimMaxCols = DIM_W'(MAX_COLS);

  // Input beat kinds (tuser)
  typedef enum logic [1:0] {
    CMD_LOAD_HAY = 2'd0,
    CMD_LOAD_PAT = 2'd1,
    CMD_SEARCH   = 2'd2
  } op_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HAY_ROWS = 2'd0,
    CFG_HAY_COLS = 2'd1,
    CFG_PAT_ROWS = 2'd2,
    CFG_PAT_COLS = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DONE
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;      // input beat taken this cycle
    logic rd_en;       // read both stores at current element
    logic elem_next;   // step to next pattern element
    logic pos_next;    // step to next candidate position
    logic match;       // current position matched
    logic emit_final;  // send closing result
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_search;
    logic fits;
    logic eq;
    logic elem_last;
    logic pos_last;
    logic pending_v;
    logic out_free;
  } dp_status_t;

  // Zero reads as one, anything above the maximum reads as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
    return ADDR_W'(r * MAX_COLS + c);
  endfunction

endpackage

// ===== rtl/ssu_ctrl.sv =====
// Sequencing state machine for the submatrix search unit.
// Depends on ssu_pkg; drives ssu_dp through ctrl_cmd_t.
module ssu_ctrl import ssu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.is_search) begin
          state_d = status_i.fits ? ST_READ : ST_DONE;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_CMP;
      end
      ST_CMP: begin
        if (!status_i.eq) begin
          cmd_o.pos_next = 1'b1;
          state_d        = status_i.pos_last ? ST_DONE : ST_READ;
        end else if (!status_i.elem_last) begin
          cmd_o.elem_next = 1'b1;
          state_d         = ST_READ;
        end else if (!status_i.pending_v || status_i.out_free) begin
          // older match goes out, this one becomes the held result
          cmd_o.match    = 1'b1;
          cmd_o.pos_next = 1'b1;
          state_d        = status_i.pos_last ? ST_DONE : ST_READ;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.emit_final = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ssu_dp.sv =====
// Datapath of the submatrix search unit: config registers, element stores,
// scan counters, comparator, held match and output register. Uses ssu_pkg.
module ssu_dp import ssu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  input  logic [1:0]           in_cmd_i,
  input  logic [ROW_W-1:0]     in_row_i,
  input  logic [COL_W-1:0]     in_col_i,
  input  logic [VAL_W-1:0]     in_value_i,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 out_found_o,
  output logic [ROW_W-1:0]     out_row_o,
  output logic [COL_W-1:0]     out_col_o,
  output logic [CNT_W-1:0]     out_count_o,
  output logic                 out_last_o
);

  logic [DIM_W-1:0] hay_rows_q, hay_cols_q, pat_rows_q, pat_cols_q;
  logic [DIM_W-1:0] hr, hc, pr, pc;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hay_rows_q <= DIM_W'(8);
      hay_cols_q <= DIM_W'(8);
      pat_rows_q <= DIM_W'(1);
      pat_cols_q <= DIM_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HAY_ROWS: hay_rows_q <= cfg_data_i;
        CFG_HAY_COLS: hay_cols_q <= cfg_data_i;
        CFG_PAT_ROWS: pat_rows_q <= cfg_data_i;
        CFG_PAT_COLS: pat_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign hr = clamp_dim(hay_rows_q, DimMaxRows);
  assign hc = clamp_dim(hay_cols_q, DimMaxCols);
  assign pr = clamp_dim(pat_rows_q, DimMaxRows);
  assign pc = clamp_dim(pat_cols_q, DimMaxCols);

  // Scan counters: position (i, j) and pattern element (a, b)
  logic [ROW_W-1:0] i_q, a_q;
  logic [COL_W-1:0] j_q, b_q;
  logic             start;
  logic             elem_last, pos_last, row_end;

  assign start     = cmd_i.accept && (in_cmd_i == CMD_SEARCH);
  assign elem_last = (DIM_W'(a_q) + DIM_W'(1) == pr) && (DIM_W'(b_q) + DIM_W'(1) == pc);
  assign row_end   = (DIM_W'(j_q) + pc == hc);
  assign pos_last  = (DIM_W'(i_q) + pr == hr) && row_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
      a_q <= '0;
      b_q <= '0;
    end else if (start) begin
      i_q <= '0;
      j_q <= '0;
      a_q <= '0;
      b_q <= '0;
    end else if (cmd_i.pos_next) begin
      a_q <= '0;
      b_q <= '0;
      if (row_end) begin
        j_q <= '0;
        i_q <= i_q + ROW_W'(1);
      end else begin
        j_q <= j_q + COL_W'(1);
      end
    end else if (cmd_i.elem_next) begin
      if (DIM_W'(b_q) + DIM_W'(1) == pc) begin
        b_q <= '0;
        a_q <= a_q + ROW_W'(1);
      end else begin
        b_q <= b_q + COL_W'(1);
      end
    end
  end

  // Element stores, one write and one registered read each
  logic [VAL_W-1:0]  hay_mem [DEPTH];
  logic [VAL_W-1:0]  pat_mem [DEPTH];
  logic [VAL_W-1:0]  hay_rd_q, pat_rd_q;
  logic [ADDR_W-1:0] wr_addr, hay_rd_addr, pat_rd_addr;

  assign wr_addr     = mem_addr(in_row_i, in_col_i);
  assign hay_rd_addr = mem_addr(i_q + a_q, j_q + b_q);
  assign pat_rd_addr = mem_addr(a_q, b_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (in_cmd_i == CMD_LOAD_HAY)) begin
      hay_mem[wr_addr] <= in_value_i;
    end
    if (cmd_i.rd_en) begin
      hay_rd_q <= hay_mem[hay_rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (in_cmd_i == CMD_LOAD_PAT)) begin
      pat_mem[wr_addr] <= in_value_i;
    end
    if (cmd_i.rd_en) begin
      pat_rd_q <= pat_mem[pat_rd_addr];
    end
  end

  // Held match: sent once the next match or the end of the scan is known
  logic             pend_v_q;
  logic [ROW_W-1:0] pend_row_q;
  logic [COL_W-1:0] pend_col_q;
  logic [CNT_W-1:0] pend_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
    end else if (start) begin
      pend_v_q <= 1'b0;
    end else if (cmd_i.match) begin
      pend_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      pend_cnt_q <= '0;
    end else if (cmd_i.match) begin
      pend_row_q <= i_q;
      pend_col_q <= j_q;
      pend_cnt_q <= pend_cnt_q + CNT_W'(1);
    end
  end

  // Output register
  logic             out_valid_q, out_found_q, out_last_q;
  logic [ROW_W-1:0] out_row_q;
  logic [COL_W-1:0] out_col_q;
  logic [CNT_W-1:0] out_cnt_q;
  logic             out_free, emit_mid;

  assign out_free = !out_valid_q || out_ready_i;
  assign emit_mid = cmd_i.match && pend_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_mid || cmd_i.emit_final) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_mid || cmd_i.emit_final) begin
      out_found_q <= pend_v_q;
      out_row_q   <= pend_v_q ? pend_row_q : '0;
      out_col_q   <= pend_v_q ? pend_col_q : '0;
      out_cnt_q   <= pend_v_q ? pend_cnt_q : '0;
      out_last_q  <= cmd_i.emit_final;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_found_o = out_found_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_count_o = out_cnt_q;
  assign out_last_o  = out_last_q;

  // Status to controller
  assign status_o.is_search = (in_cmd_i == CMD_SEARCH);
  assign status_o.fits      = (pr <= hr) && (pc <= hc);
  assign status_o.eq        = (hay_rd_q == pat_rd_q);
  assign status_o.elem_last = elem_last;
  assign status_o.pos_last  = pos_last;
  assign status_o.pending_v = pend_v_q;
  assign status_o.out_free  = out_free;

endmodule

// ===== rtl/submatrix_search_unit.sv =====
// Top level of the submatrix search unit: stream ports, config port,
// controller (ssu_ctrl) and datapath (ssu_dp). Uses ssu_pkg.

// Load beats (tuser 0: haystack element, 1: pattern element) write one 32-bit
// element at (row, col); kind 3 is dropped. A search beat scans every
// top-left position where the pattern fits, in row-major order, and sends one
// result per exact match with its position and running count; the final
// result carries tlast and the total, or found=0 with zero fields when nothing
// matches. Each compared element takes a store read, then a compare, because
// each store has a single registered read port, and a position stops at its
// first mismatch; a search is also held while the result side stalls. A match
// is sent only when the next match or the end of the scan is reached. No new
// beat is taken until the last result of a search has been loaded into the
// output register. Dimension registers (0: hay_rows, 1: hay_cols, 2: pat_rows,
// 3: pat_cols) read 0 as 1 and values above 8 as 8; write them only while the
// unit is idle.
module submatrix_search_unit import ssu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [39:0]          s_axis_tdata,  // row[2:0], col[5:3], value[37:6], zero pad
  input  logic [1:0]           s_axis_tuser,  // cmd[1:0]
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,  // match_row[2:0], match_col[5:3],
                                              // match_count[12:6], zero pad
  output logic                 m_axis_tuser,  // found
  output logic                 m_axis_tlast
);

  ctrl_cmd_t        cmd;
  dp_status_t       status;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic [CNT_W-1:0] out_cnt;

  ssu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ssu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_cmd_i    (s_axis_tuser),
    .in_row_i    (s_axis_tdata[2:0]),
    .in_col_i    (s_axis_tdata[5:3]),
    .in_value_i  (s_axis_tdata[37:6]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_found_o (m_axis_tuser),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .out_count_o (out_cnt),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_cnt, out_col, out_row};

  // A not-found result is always the closing one and carries zero fields
  a_notfound_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == '0)))
    else $error("not-found result without tlast or with nonzero fields");

  // A match result always counts at least itself and never more than all positions
  a_match_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      ((m_axis_tdata[12:6] != 7'd0) && (m_axis_tdata[12:6] <= 7'd64)))
    else $error("match count out of range");

  // Input is taken only while no search is in progress
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.rd_en || cmd.match || cmd.pos_next) |-> !s_axis_tready)
    else $error("input ready during a search");

endmodule

// ===== sim/submatrix_search_unit_tb.sv =====
// Self-checking testbench for submatrix_search_unit: stream stimulus with bursty input and
// a stalling result side, checked beat by beat against a behavioral match predictor.
// Depends on ssu_pkg and the submatrix_search_unit RTL.
module submatrix_search_unit_tb import ssu_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT   = 500000;
  localparam int          RAND_ITEMS    = 150;
  localparam int          SETTLE_CYCLES = 8;
  localparam logic [1:0]  CMD_UNUSED    = 2'd3;
  localparam logic [31:0] V_MIN         = 32'h8000_0000;
  localparam logic [31:0] V_MAX         = 32'h7FFF_FFFF;
  localparam logic [31:0] V_ONES        = 32'hFFFF_FFFF;

  // One result beat as the unit should send it
  typedef struct packed {
    logic       found;
    logic [2:0] mrow;
    logic [2:0] mcol;
    logic [6:0] cnt;
    logic       last;
  } hit_t;

  localparam hit_t NO_HIT  = '{1'b0, 3'd0, 3'd0, 7'd0, 1'b1};
  localparam hit_t HIT_0_0 = '{1'b1, 3'd0, 3'd0, 7'd1, 1'b1};
  localparam hit_t HIT_0_1 = '{1'b1, 3'd0, 3'd1, 7'd1, 1'b1};

  // Directed step: a register write or an input beat
  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  code;   // command, or register index on a register row
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;  // element value, or register value
    logic        typed;  // want is the only result of this beat
    hit_t        want;
  } step_t;

  localparam int PLAN_LEN = 31;
  localparam step_t PLAN [PLAN_LEN] = '{
    // 1 x 2 haystack, 1 x 8 pattern (zero reads as one, 15 as eight): nothing fits
    '{1'b1, CFG_HAY_ROWS, 3'd0, 3'd0, 32'd0,  1'b0, NO_HIT},
    '{1'b1, CFG_HAY_COLS, 3'd0, 3'd0, 32'd2,  1'b0, NO_HIT},
    '{1'b1, CFG_PAT_ROWS, 3'd0, 3'd0, 32'd0,  1'b0, NO_HIT},
    '{1'b1, CFG_PAT_COLS, 3'd0, 3'd0, 32'd15, 1'b0, NO_HIT},
    '{1'b0, CMD_SEARCH,   3'd0, 3'd0, 32'd0,  1'b1, NO_HIT},
    // single element pattern against the value extremes
    '{1'b1, CFG_PAT_COLS, 3'd0, 3'd0, 32'd1,  1'b0, NO_HIT},
    '{1'b0, CMD_LOAD_HAY, 3'd0, 3'd0, V_MIN,  1'b0, NO_HIT},
    '{1'b0, CMD_LOAD_HAY, 3'd0, 3'd1, V_MAX,  1'b0, NO_HIT},
    '{1'b0, CMD_LOAD_PAT, 3'd0, 3'd0, V_MAX,  1'b0, NO_HIT},
    '{1'b0, CMD_SEARCH,   3'd0, 3'd0, 32'd0,  1'b1, HIT_0_1},
    '{1'b0, CMD_LOAD_PAT, 3'd0, 3'd0, V_MIN,  1'b0, NO_HIT},
    '{1'b0, CMD_SEARCH,   3'd0, 3'd0, 32'd0,  1'b1, HIT_0_0},
    // unknown command is dropped
    '{1'b0, CMD_UNUSED,   3'd7, 3'd7, V_ONES, 1'b0, NO_HIT},
    '{1'b0, CMD_LOAD_PAT, 3'd0, 3'd0, 32'd0,  1'b0, NO_HIT},
    '{1'b0, CMD_SEARCH,   3'd0, 3'd0, 32'd0,  1'b1, NO_HIT},
    // far corner of both stores
    '{1'b0, CMD_LOAD_HAY, 3'd7, 3'd7, V_ONES, 1'b0, NO_HIT},
    '{1'b0, CMD_LOAD_PAT, 3'd7, 3'd7, V_ONES, 1'b0, NO_HIT},
    // uniform 2 x 2 haystack: every position matches
    '{1'b1, CFG_HAY_ROWS, 3'd0, 3'd0, 32'd2,  1'b0, NO_HIT},
    '{1'b1, CFG_HAY_COLS, 3'd0, 3'd0, 32'd2,  1'b0, NO_HIT},
    '{1'b0, CMD_LOAD_HAY, 3'd0, 3'd0, 32'd5,  1'b0, NO_HIT},
    '{1'b0, CMD_LOAD_HAY, 3'd0, 3'd1, 32'd5,  1'b0, NO_HIT},
    '{1'b0, CMD_LOAD_HAY, 3'd1, 3'd0, 32'd5,  1'b0, NO_HIT},
    '{1'b0, CMD_LOAD_HAY, 3'd1, 3'd1, 32'd5,  1'b0, NO_HIT},
    '{1'b0, CMD_LOAD_PAT, 3'd0, 3'd0, 32'd5,  1'b0, NO_HIT},
    '{1'b0, CMD_SEARCH,   3'd0, 3'd0, 32'd0,  1'b0, NO_HIT},
    // pattern as large as the haystack
    '{1'b1, CFG_PAT_ROWS, 3'd0, 3'd0, 32'd2,  1'b0, NO_HIT},
    '{1'b1, CFG_PAT_COLS, 3'd0, 3'd0, 32'd2,  1'b0, NO_HIT},
    '{1'b0, CMD_LOAD_PAT, 3'd0, 3'd1, 32'd5,  1'b0, NO_HIT},
    '{1'b0, CMD_LOAD_PAT, 3'd1, 3'd0, 32'd5,  1'b0, NO_HIT},
    '{1'b0, CMD_LOAD_PAT, 3'd1, 3'd1, 32'd5,  1'b0, NO_HIT},
    '{1'b0, CMD_SEARCH,   3'd0, 3'd0, 32'd0,  1'b1, HIT_0_0}
  };

  logic                 clk;
  logic                 rst_n    = 1'b0;
  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 s_valid  = 1'b0;
  logic                 s_ready;
  logic [39:0]          s_data   = '0;  // row[2:0], col[5:3], value[37:6], zero pad
  logic [1:0]           s_user   = '0;  // cmd[1:0]
  logic                 m_valid;
  logic                 m_ready  = 1'b0;
  logic [15:0]          m_data;         // match_row[2:0], match_col[5:3], match_count[12:6]
  logic                 m_user;         // found
  logic                 m_last;

  // Shadow of the unit: stores, written flags, raw dimension registers
  logic [31:0] hay_mem [DEPTH];
  logic [31:0] pat_mem [DEPTH];
  bit          hay_set [DEPTH];
  bit          pat_set [DEPTH];
  logic [3:0]  dim_hr = 4'd8;
  logic [3:0]  dim_hc = 4'd8;
  logic [3:0]  dim_pr = 4'd1;
  logic [3:0]  dim_pc = 4'd1;

  hit_t hit_q [$];
  int   err_cnt    = 0;
  int   item_cnt   = 0;
  int   cyc        = 0;
  int   burst_left = 0;
  bit   vld_hold   = 1'b0;
  int   ready_run  = 0;

  submatrix_search_unit u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: runs of ready and stall, each run's kind picked at random
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_ready   <= 1'b0;
      ready_run <= 0;
    end else if (ready_run == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        m_ready   <= 1'b0;
        ready_run <= $urandom_range(1, 6);
      end else begin
        m_ready   <= 1'b1;
        ready_run <= $urandom_range(1, 24);
      end
    end else begin
      ready_run <= ready_run - 1;
    end
  end

  function automatic void cmp_field(input string name, input logic [31:0] want_v,
                                    input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
      err_cnt++;
    end
  endfunction

  // Each result beat against the oldest expectation
  always @(posedge clk) begin : result_chk
    hit_t want;
    if (rst_n && m_valid && m_ready) begin
      if (hit_q.size() == 0) begin
        $display("%0t: expected no result, actual found %0d row %0d col %0d",
                 $time, m_user, m_data[2:0], m_data[5:3],
                 " count %0d last %0d", m_data[12:6], m_last);
        err_cnt++;
      end else begin
        want = hit_q.pop_front();
        cmp_field("found", 32'(want.found), 32'(m_user));
        cmp_field("match_row", 32'(want.mrow), 32'(m_data[2:0]));
        cmp_field("match_col", 32'(want.mcol), 32'(m_data[5:3]));
        cmp_field("match_count", 32'(want.cnt), 32'(m_data[12:6]));
        cmp_field("last", 32'(want.last), 32'(m_last));
      end
    end
  end

  // Zero counts as one, anything over the store size as the store size
  function automatic int limit_dim(input logic [3:0] v, input int top);
    if (v == 4'd0) return 1;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  // Row-major scan of every position where the pattern fits
  function automatic void push_matches();
    int  hr, hc, pr, pc, n;
    bit  ok;
    hr = limit_dim(dim_hr, MAX_ROWS);
    hc = limit_dim(dim_hc, MAX_COLS);
    pr = limit_dim(dim_pr, MAX_ROWS);
    pc = limit_dim(dim_pc, MAX_COLS);
    n  = 0;
    if (pr <= hr && pc <= hc) begin
      for (int i = 0; i + pr <= hr; i++) begin
        for (int j = 0; j + pc <= hc; j++) begin
          ok = 1'b1;
          for (int a = 0; a < pr; a++) begin
            for (int b = 0; b < pc; b++) begin
              if (pat_mem[a*MAX_COLS + b] != hay_mem[(i+a)*MAX_COLS + j + b]) ok = 1'b0;
            end
          end
          if (ok) begin
            n++;
            hit_q.push_back('{1'b1, 3'(i), 3'(j), 7'(n), 1'b0});
          end
        end
      end
    end
    if (n == 0) hit_q.push_back(NO_HIT);
    else hit_q[hit_q.size()-1].last = 1'b1;
  endfunction

  function automatic void predict_beat(input logic [1:0] cmd, input logic [2:0] row, col,
                                       input logic [31:0] val);
    case (cmd)
      CMD_LOAD_HAY: begin
        hay_mem[{row, col}] = val;
        hay_set[{row, col}] = 1'b1;
      end
      CMD_LOAD_PAT: begin
        pat_mem[{row, col}] = val;
        pat_set[{row, col}] = 1'b1;
      end
      CMD_SEARCH: push_matches();
      default: ;
    endcase
  endfunction

  // Present one beat and return at the edge that takes it; bursts with random gaps
  task automatic drive_beat(input logic [1:0] cmd, input logic [2:0] row, col,
                            input logic [31:0] val);
    if (!vld_hold) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      s_valid <= 1'b1;
    end
    s_user <= cmd;
    s_data <= {2'b00, val, col, row};
    do @(posedge clk); while (!s_ready);
    burst_left--;
    if (burst_left == 0) begin
      s_valid  <= 1'b0;
      vld_hold = 1'b0;
    end else begin
      vld_hold = 1'b1;
    end
  endtask

  task automatic send_beat(input logic [1:0] cmd, input logic [2:0] row, col,
                           input logic [31:0] val);
    drive_beat(cmd, row, col, val);
    predict_beat(cmd, row, col, val);
    if (cmd != CMD_UNUSED) item_cnt++;
  endtask

  // Drain: stop the input, wait for every result, then let loads retire
  task automatic settle();
    if (vld_hold) begin
      s_valid  <= 1'b0;
      vld_hold = 1'b0;
    end
    while (hit_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dim(input cfg_idx_e idx, input logic [3:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_HAY_ROWS: dim_hr = v;
      CFG_HAY_COLS: dim_hc = v;
      CFG_PAT_ROWS: dim_pr = v;
      CFG_PAT_COLS: dim_pc = v;
      default: ;
    endcase
  endtask

  // Mostly small sizes; now and then zero, eight, or above eight
  function automatic logic [3:0] pick_dim(input bit for_pat);
    int roll;
    roll = for_pat ? $urandom_range(0, 15) : $urandom_range(0, 9);
    if (roll == 0) return 4'd0;
    if (roll == 1) return 4'($urandom_range(9, 15));
    if (roll == 2) return 4'd8;
    if (for_pat) return 4'($urandom_range(1, (roll < 12) ? 2 : 4));
    return 4'($urandom_range(1, (roll < 7) ? 4 : 7));
  endfunction

  // Full-range values, or a two-letter alphabet with rare extremes so matches happen
  function automatic logic [31:0] pick_value(input int mode);
    if (mode == 0) return $urandom;
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? V_MIN : V_MAX;
    return $urandom_range(0, 1);
  endfunction

  initial begin
    int k, s, a, b, i, j, hr, hc, pr, pc, mode, n_srch, phase;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (k = 0; k < PLAN_LEN; k++) begin
      if (PLAN[k].is_cfg) begin
        settle();
        write_dim(cfg_idx_e'(PLAN[k].code), PLAN[k].value[3:0]);
      end else if (PLAN[k].typed) begin
        drive_beat(PLAN[k].code, PLAN[k].row, PLAN[k].col, PLAN[k].value);
        hit_q.push_back(PLAN[k].want);
      end else begin
        send_beat(PLAN[k].code, PLAN[k].row, PLAN[k].col, PLAN[k].value);
      end
    end

    // Random phases, each with its own sizes and value mix
    phase = 0;
    while (item_cnt < RAND_ITEMS) begin
      settle();
      write_dim(CFG_HAY_ROWS, pick_dim(1'b0));
      write_dim(CFG_HAY_COLS, pick_dim(1'b0));
      write_dim(CFG_PAT_ROWS, pick_dim(1'b1));
      write_dim(CFG_PAT_COLS, pick_dim(1'b1));
      hr = limit_dim(dim_hr, MAX_ROWS);
      hc = limit_dim(dim_hc, MAX_COLS);
      pr = limit_dim(dim_pr, MAX_ROWS);
      pc = limit_dim(dim_pc, MAX_COLS);
      mode = (phase == 0) ? 0 : $urandom_range(0, 3);
      phase++;
      n_srch = $urandom_range(1, 3);
      for (s = 0; s < n_srch && item_cnt < RAND_ITEMS; s++) begin
        // stray loads anywhere in either store, and some noise
        repeat ($urandom_range(0, 4))
          send_beat(2'($urandom_range(0, 1)), 3'($urandom), 3'($urandom), pick_value(mode));
        if ($urandom_range(0, 7) == 0)
          send_beat(CMD_UNUSED, 3'($urandom), 3'($urandom), $urandom);
        if (pr <= hr && pc <= hc) begin
          // every haystack entry the scan can touch holds data
          for (a = 0; a < hr; a++)
            for (b = 0; b < hc; b++)
              if (!hay_set[a*MAX_COLS + b])
                send_beat(CMD_LOAD_HAY, 3'(a), 3'(b), pick_value(mode));
          // usually the pattern is cut out of the haystack
          if ($urandom_range(0, 3) != 0) begin
            i = $urandom_range(0, hr - pr);
            j = $urandom_range(0, hc - pc);
            for (a = 0; a < pr; a++)
              for (b = 0; b < pc; b++)
                send_beat(CMD_LOAD_PAT, 3'(a), 3'(b), hay_mem[(i+a)*MAX_COLS + j + b]);
          end
          for (a = 0; a < pr; a++)
            for (b = 0; b < pc; b++)
              if (!pat_set[a*MAX_COLS + b])
                send_beat(CMD_LOAD_PAT, 3'(a), 3'(b), pick_value(mode));
          // spoil one pattern element now and then
          if ($urandom_range(0, 4) == 0)
            send_beat(CMD_LOAD_PAT, 3'($urandom_range(0, pr - 1)),
                      3'($urandom_range(0, pc - 1)), pick_value(mode));
        end
        send_beat(CMD_SEARCH, 3'($urandom), 3'($urandom), $urandom);
      end
    end

    settle();
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
